// File: hw/rtl/frag_pkg.sv
`timescale 1ns / 1ps

package frag_pkg;

  // default capacity of the blob store in bytes
  localparam int unsigned BLOB_BYTES_DEF = 64;

  // header bytes at the front of every fragment: flags, index low, index high
  localparam int unsigned HEADER_BYTES = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       fragment_end;
  } frag_in_t;

  typedef struct packed {
    logic [7:0] blob_byte;
    logic       blob_last;
    logic       blob_empty;
  } frag_out_t;

endpackage

// File: hw/rtl/fragment_reassembler_core.sv
`timescale 1ns / 1ps

// channel   direction  payload      handshake
// frag      in         frag_in_t    frag_valid / frag_stall
// blob      out        frag_out_t   blob_valid / blob_stall
//
// for a fragment byte, header, payload and fragment end are all
// handled in the cycle the transaction is accepted
// a completed blob comes out byte by byte, each read from the registered
// read port of the blob store, then loaded into the output register
// the frag channel is stalled while a blob is being read out; an empty
// marker goes out in the cycle after its final fragment ends
// rst is synchronous and clears all control state; the blob store needs no
// clearing pass since only bytes below the fill count are ever read
// a stalled output keeps its transaction; new fragment bytes are still taken
// while the last blob byte waits, unless that waiting byte is being stalled

module fragment_reassembler_core #(
  parameter int unsigned BLOB_BYTES = frag_pkg::BLOB_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                frag_valid,
  output logic                frag_stall,
  input  frag_pkg::frag_in_t  frag,
  output logic                blob_valid,
  input  logic                blob_stall,
  output frag_pkg::frag_out_t blob
);

  import frag_pkg::*;

  // store address and fill count widths
  localparam int unsigned AW = (BLOB_BYTES > 1) ? $clog2(BLOB_BYTES) : 1;
  localparam int unsigned LW = $clog2(BLOB_BYTES + 1);

  // header progress within a fragment
  localparam logic [1:0] HDR_FLAGS = 2'd0;
  localparam logic [1:0] HDR_IDX_LO = 2'd1;
  localparam logic [1:0] HDR_IDX_HI = 2'd2;
  localparam logic [1:0] HDR_DONE = 2'(HEADER_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,   // taking fragment bytes
    S_READ,   // blob store read in flight
    S_LOAD    // read data ready, waiting for a free output register
  } state_t;

  state_t state;

  // per-fragment header state
  logic [1:0]    header_count;
  logic          final_seen;
  logic [7:0]    index_low_byte;
  logic          dropping_fragment;
  logic          overflowed;

  // per-blob state
  logic [15:0]   expected_index;
  logic [LW-1:0] blob_length;

  // readout pointer
  logic [LW-1:0] rd_ptr;

  // blob store: one write port while taking bytes, one registered read port
  logic [7:0]    blob_store [BLOB_BYTES];
  logic [7:0]    rd_data;
  logic          wr_en;

  // next values computed for an accepted fragment byte
  logic [1:0]    header_count_next;
  logic          final_seen_next;
  logic [7:0]    index_low_byte_next;
  logic          dropping_fragment_next;
  logic          overflowed_next;
  logic [15:0]   expected_index_next;
  logic [LW-1:0] blob_length_next;
  logic          emit_marker;
  logic          emit_blob;

  logic          frag_take;
  logic          blob_take;
  logic          out_free;
  logic          load_out;
  logic [15:0]   frag_index;
  logic          rd_last;

  assign frag_take  = frag_valid && !frag_stall;
  assign blob_take  = blob_valid && !blob_stall;
  // output register can take a new transaction this cycle
  assign out_free   = !blob_valid || !blob_stall;
  // output register gets a marker or a blob byte this cycle
  assign load_out   = ((state == S_IDLE) && frag_take && emit_marker) ||
                      ((state == S_LOAD) && out_free);
  assign frag_stall = (state != S_IDLE) || (blob_valid && blob_stall);
  assign frag_index = {frag.data_byte, index_low_byte};
  assign rd_last    = (LW'(rd_ptr + 1'b1) == blob_length);

  // header parse, payload append and fragment end for one byte
  always_comb begin
    header_count_next      = header_count;
    final_seen_next        = final_seen;
    index_low_byte_next    = index_low_byte;
    dropping_fragment_next = dropping_fragment;
    overflowed_next        = overflowed;
    expected_index_next    = expected_index;
    blob_length_next       = blob_length;
    wr_en                  = 1'b0;
    emit_marker            = 1'b0;
    emit_blob              = 1'b0;

    case (header_count)
      HDR_FLAGS: begin
        final_seen_next   = frag.data_byte[0];
        header_count_next = HDR_IDX_LO;
      end
      HDR_IDX_LO: begin
        index_low_byte_next = frag.data_byte;
        header_count_next   = HDR_IDX_HI;
      end
      HDR_IDX_HI: begin
        header_count_next = HDR_DONE;
        // out-of-order index: drop the partial blob; index zero starts anew
        if (frag_index != expected_index) begin
          blob_length_next    = '0;
          expected_index_next = '0;
          if (frag_index != 16'd0) begin
            dropping_fragment_next = 1'b1;
          end
        end
      end
      default: begin
        if (!dropping_fragment && !overflowed) begin
          if (blob_length < LW'(BLOB_BYTES)) begin
            wr_en            = frag_take;
            blob_length_next = LW'(blob_length + 1'b1);
          end else begin
            overflowed_next = 1'b1;
          end
        end
      end
    endcase

    if (frag.fragment_end) begin
      if (header_count_next != HDR_DONE || overflowed_next) begin
        // short fragment or overflow: discard the whole blob
        blob_length_next    = '0;
        expected_index_next = '0;
      end else if (!dropping_fragment_next) begin
        if (!final_seen_next) begin
          expected_index_next = 16'(expected_index_next + 1'b1);
        end else begin
          expected_index_next = '0;
          if (blob_length_next == '0) begin
            emit_marker = 1'b1;
          end else begin
            emit_blob = 1'b1;
          end
        end
      end
      header_count_next      = HDR_FLAGS;
      final_seen_next        = 1'b0;
      index_low_byte_next    = '0;
      dropping_fragment_next = 1'b0;
      overflowed_next        = 1'b0;
    end
  end

  // blob store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      blob_store[blob_length[AW-1:0]] <= frag.data_byte;
    end
    rd_data <= blob_store[rd_ptr[AW-1:0]];
  end

  // control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      header_count      <= HDR_FLAGS;
      final_seen        <= 1'b0;
      index_low_byte    <= '0;
      dropping_fragment <= 1'b0;
      overflowed        <= 1'b0;
      expected_index    <= '0;
      blob_length       <= '0;
      rd_ptr            <= '0;
      blob_valid        <= 1'b0;
    end else begin
      if (load_out) begin
        blob_valid <= 1'b1;
      end else if (blob_take) begin
        blob_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (frag_take) begin
            header_count      <= header_count_next;
            final_seen        <= final_seen_next;
            index_low_byte    <= index_low_byte_next;
            dropping_fragment <= dropping_fragment_next;
            overflowed        <= overflowed_next;
            expected_index    <= expected_index_next;
            if (emit_marker) begin
              // empty blob: single marker, store is already empty
              blob.blob_byte  <= '0;
              blob.blob_last  <= 1'b1;
              blob.blob_empty <= 1'b1;
              blob_length     <= '0;
            end else begin
              blob_length <= blob_length_next;
            end
            if (emit_blob) begin
              rd_ptr <= '0;
              state  <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            blob.blob_byte  <= rd_data;
            blob.blob_last  <= rd_last;
            blob.blob_empty <= 1'b0;
            rd_ptr          <= LW'(rd_ptr + 1'b1);
            if (rd_last) begin
              blob_length <= '0;
              state       <= S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // fill count never exceeds the store
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    blob_length <= LW'(BLOB_BYTES))
    else $error("blob length beyond store capacity");

  // readout stays inside the buffered bytes
  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (rd_ptr < blob_length))
    else $error("readout pointer past blob length");

  // an empty marker is always the last transaction of its blob
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (blob_valid && blob.blob_empty) |-> blob.blob_last)
    else $error("empty marker without last flag");

  // a fragment is only dropped after its full header
  a_drop_after_header: assert property (@(posedge clk) disable iff (rst)
    dropping_fragment |-> (header_count == HDR_DONE))
    else $error("dropping before header complete");

  // each store read is followed by a load attempt
  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_LOAD))
    else $error("read not followed by load");

endmodule

// File: tb/tb_fragment_reassembler_core.sv
`timescale 1ns / 1ps

module tb_fragment_reassembler_core;
  import frag_pkg::*;

  localparam int unsigned BLOB_CAP     = BLOB_BYTES_DEF;
  localparam int          CLK_PERIOD   = 8;
  localparam int          RESET_CYCLES = 2;
  localparam int          TOTAL_BYTES  = 480;
  localparam int          DRAIN_CYCLES = 24;
  localparam int          FINAL_BIT    = 0;
  localparam int          HOLD_EVERY   = 160;
  localparam int          HOLD_COUNT   = 2;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      frag_valid;
  logic      frag_stall;
  frag_in_t  frag;
  logic      blob_valid;
  logic      blob_stall;
  frag_out_t blob;

  frag_in_t  frag_byte_q[$];
  frag_out_t blob_byte_q[$];

  // reassembly state mirrored from the block
  logic [1:0]  hdr_cnt     = '0;
  logic        final_flag  = 1'b0;
  logic [7:0]  idx_lo      = '0;
  logic [15:0] want_idx    = '0;
  logic        drop_frag   = 1'b0;
  logic        ovf         = 1'b0;
  logic [7:0]  store [BLOB_CAP];
  logic [6:0]  fill        = '0;

  int          mismatches  = 0;
  int          frags_taken = 0;
  bit          frag_taken  = 1'b0;
  frag_out_t   want;

  int          gap_left    = 0;
  int          burst_left  = 0;
  int          hold_left   = 0;
  int          hold_step   = 0;
  int          mode_left   = 0;
  stall_mode_t stall_mode  = STALL_NONE;

  fragment_reassembler_core #(
    .BLOB_BYTES(BLOB_CAP)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .frag_valid(frag_valid),
    .frag_stall(frag_stall),
    .frag      (frag),
    .blob_valid(blob_valid),
    .blob_stall(blob_stall),
    .blob      (blob)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // expected blob bytes for one accepted fragment byte
  task automatic reassemble_byte(input frag_in_t t);
    logic [15:0] idx;
    frag_out_t   o;
    if (hdr_cnt == 2'd0) begin
      final_flag = t.data_byte[FINAL_BIT];
      hdr_cnt = 2'd1;
    end else if (hdr_cnt == 2'd1) begin
      idx_lo = t.data_byte;
      hdr_cnt = 2'd2;
    end else if (hdr_cnt == 2'd2) begin
      idx = {t.data_byte, idx_lo};
      hdr_cnt = 2'd3;
      if (idx != want_idx) begin
        fill = '0;
        want_idx = '0;
        if (idx != 16'd0) drop_frag = 1'b1;
      end
    end else if (!drop_frag && !ovf) begin
      if (fill < BLOB_CAP) begin
        store[fill[5:0]] = t.data_byte;
        fill = fill + 7'd1;
      end else begin
        ovf = 1'b1;
      end
    end

    if (t.fragment_end) begin
      if (hdr_cnt < HEADER_BYTES || ovf) begin
        fill = '0;
        want_idx = '0;
      end else if (!drop_frag) begin
        if (!final_flag) begin
          want_idx = want_idx + 16'd1;
        end else begin
          if (fill == 0) begin
            o.blob_byte = 8'd0;
            o.blob_last = 1'b1;
            o.blob_empty = 1'b1;
            blob_byte_q = {blob_byte_q, o};
          end else begin
            for (int i = 0; i < fill; i++) begin
              o.blob_byte = store[6'(i)];
              o.blob_last = (i == fill - 1);
              o.blob_empty = 1'b0;
              blob_byte_q = {blob_byte_q, o};
            end
          end
          fill = '0;
          want_idx = '0;
        end
      end
      hdr_cnt = '0;
      final_flag = 1'b0;
      idx_lo = '0;
      drop_frag = 1'b0;
      ovf = 1'b0;
    end
  endtask

  task automatic add_byte(input logic [7:0] b, input logic e);
    frag_in_t t;
    t.data_byte = b;
    t.fragment_end = e;
    frag_byte_q = {frag_byte_q, t};
  endtask

  task automatic add_header(input logic [7:0] flags, input logic [15:0] idx, input logic e);
    add_byte(flags, 1'b0);
    add_byte(idx[7:0], 1'b0);
    add_byte(idx[15:8], e);
  endtask

  task automatic add_fragment(input logic [7:0] flags, input logic [15:0] idx, input int len);
    add_header(flags, idx, len == 0);
    for (int i = 0; i < len; i++) add_byte(8'($urandom), i == len - 1);
  endtask

  // random upper flag bits, final bit as given
  function automatic logic [7:0] rand_flags(input logic is_final);
    logic [7:0] f;
    f = 8'($urandom);
    f[FINAL_BIT] = is_final;
    return f;
  endfunction

  // accept side: prediction and result checks, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      frag_taken = frag_valid && !frag_stall;
      if (frag_taken) begin
        reassemble_byte(frag);
        frags_taken++;
      end
      if (blob_valid && !blob_stall) begin
        if (blob_byte_q.size() == 0) begin
          $display("%0t: unexpected blob transaction, actual %p", $time, blob);
          mismatches++;
        end else begin
          want = blob_byte_q.pop_front();
          if (blob.blob_byte !== want.blob_byte) begin
            $display("%0t: blob_byte expected %0h actual %0h", $time,
                     want.blob_byte, blob.blob_byte);
            mismatches++;
          end
          if (blob.blob_last !== want.blob_last) begin
            $display("%0t: blob_last expected %0b actual %0b", $time,
                     want.blob_last, blob.blob_last);
            mismatches++;
          end
          if (blob.blob_empty !== want.blob_empty) begin
            $display("%0t: blob_empty expected %0b actual %0b", $time,
                     want.blob_empty, blob.blob_empty);
            mismatches++;
          end
        end
      end
    end
  end

  // fragment driver: bursts with random gaps, holds a stalled transaction
  always @(negedge clk) begin
    if (rst) begin
      frag_valid <= 1'b0;
    end else if (frag_valid && !frag_taken) begin
      frag_valid <= 1'b1;
    end else if (gap_left != 0) begin
      frag_valid <= 1'b0;
      gap_left--;
    end else if (frag_byte_q.size() != 0) begin
      frag_valid <= 1'b1;
      frag <= frag_byte_q.pop_front();
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end else begin
      frag_valid <= 1'b0;
    end
  end

  // blob receiver: changing stall patterns plus a few long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      blob_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      blob_stall <= 1'b1;
    end else if (hold_step < HOLD_COUNT && frags_taken >= (hold_step + 1) * HOLD_EVERY) begin
      hold_step++;
      hold_left = $urandom_range(200, 320);
      blob_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 60);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:   blob_stall <= 1'b0;
        STALL_LIGHT:  blob_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  blob_stall <= ($urandom_range(0, 3) != 0);
        default:      blob_stall <= ~blob_stall;
      endcase
    end
  end

  initial begin : main
    int pick;
    int nfrag;
    rst = 1'b1;
    frag_valid = 1'b0;
    frag = '0;
    blob_stall = 1'b0;

    // empty final fragment, upper flag bits set
    add_header(8'hFF, 16'd0, 1'b1);
    // short fragments of one and two bytes
    add_byte(8'h01, 1'b1);
    add_byte(8'h01, 1'b0);
    add_byte(8'h00, 1'b1);
    // two-fragment blob with extreme payload bytes
    add_header(8'hFE, 16'd0, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_header(8'h01, 16'd1, 1'b0);
    add_byte(8'hA5, 1'b1);
    // wrong nonzero index drops the fragment and the blob
    add_header(8'h00, 16'd0, 1'b0);
    add_byte(8'h5A, 1'b1);
    add_header(8'h01, 16'h8001, 1'b0);
    add_byte(8'h3C, 1'b1);
    // index 0 in the middle of a blob starts a new one
    add_header(8'h00, 16'd0, 1'b0);
    add_byte(8'h11, 1'b1);
    add_header(8'h01, 16'd0, 1'b0);
    add_byte(8'h22, 1'b1);

    while (frag_byte_q.size() < TOTAL_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        nfrag = $urandom_range(1, 4);
        for (int k = 0; k < nfrag; k++)
          add_fragment(rand_flags(k == nfrag - 1), 16'(k), $urandom_range(0, 12));
      end else if (pick < 66) begin
        // store filled close to the brim, to it or just past it
        add_fragment(rand_flags(1'b1), 16'd0, $urandom_range(60, 66));
      end else if (pick < 70) begin
        // blob near or past capacity, spread across two fragments
        add_fragment(rand_flags(1'b0), 16'd0, $urandom_range(28, 36));
        add_fragment(rand_flags(1'b1), 16'd1, $urandom_range(28, 36));
      end else if (pick < 80) begin
        if ($urandom_range(0, 1) == 0) begin
          add_byte(8'($urandom), 1'b1);
        end else begin
          add_byte(8'($urandom), 1'b0);
          add_byte(8'($urandom), 1'b1);
        end
      end else if (pick < 90) begin
        add_fragment(8'($urandom), 16'($urandom), $urandom_range(0, 6));
      end else begin
        // sequence whose second index may be skipped, repeated or in order
        add_fragment(rand_flags(1'b0), 16'd0, $urandom_range(0, 8));
        add_fragment(rand_flags(1'($urandom_range(0, 1))), 16'($urandom_range(0, 3)),
                     $urandom_range(0, 8));
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (frag_byte_q.size() != 0 || frag_valid) @(posedge clk);
    while (blob_byte_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && blob_byte_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
